>>> hdl/gaq_pkg.sv
// Shared constants for the graph adjacency query engine.
`default_nettype none
package gaq_pkg;

   localparam int VIDX_W   = 6;   // vertex index field width
   localparam int COUNT_W  = 7;   // vertex count register width
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int DEG_W    = 6;

   localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_DEGREE = 2'd1;
   localparam logic [OP_W-1:0] OP_NEXT   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLIQUE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SELF  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage
`default_nettype wire

>>> hdl/gaq_if.sv
// Request and response channel interfaces.
`default_nettype none
interface gaq_req_if;
   import gaq_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic [VIDX_W-1:0]   vertex_a;
   logic [VIDX_W-1:0]   vertex_b;
   logic                edge_present;

   modport source (output valid, output opcode, output vertex_a, output vertex_b,
                   output edge_present, input ready);
   modport sink   (input valid, input opcode, input vertex_a, input vertex_b,
                   input edge_present, output ready);
endinterface

interface gaq_rsp_if;
   import gaq_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                found;
   logic [VIDX_W-1:0]   vertex_out;
   logic [DEG_W-1:0]    degree;
   logic                last;

   modport source (output valid, output status, output found, output vertex_out,
                   output degree, output last, input ready);
   modport sink   (input valid, input status, input found, input vertex_out,
                   input degree, input last, output ready);
endinterface
`default_nettype wire

>>> hdl/gaq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module gaq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> hdl/gaq_row_store.sv
// Adjacency row store: RAM plus per-row valid bits so rows read as zero until written.
`default_nettype none
module gaq_row_store #(
   parameter int MAX_VERTICES = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
   input  wire logic [MAX_VERTICES-1:0]         wr_data,
   input  wire logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
   output logic      [MAX_VERTICES-1:0]         rd_row
);

   logic [MAX_VERTICES-1:0] valid_ff, valid_in;
   logic                    rd_valid_ff;
   logic [MAX_VERTICES-1:0] rd_data;

   gaq_ram #(
      .WIDTH (MAX_VERTICES),
      .DEPTH (MAX_VERTICES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_row = rd_valid_ff ? rd_data : '0;

endmodule
`default_nettype wire

>>> hdl/graph_adjacency_query_engine_top.sv
// Sequence: a write reads row a, writes it back while reading row b, then writes row b.
// Degree / next neighbor read row a, then scan the n active rows (n = active vertex count);
// clique test: check pass over the rows, then member emission. Errors (range, self edge) go
// straight to the answer. One request in flight at a time; the rate is set by the row scan,
// one adjacency row read per cycle from one RAM port. Reset: synchronous; clears control state,
// row valid bits (store reads as no edges at once, no clearing pass) and sets vertex_count to 64.
`default_nettype none
module graph_adjacency_query_engine_top #(
   parameter int MAX_VERTICES = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   gaq_req_if.sink                           req_chan,
   gaq_rsp_if.source                         rsp_chan,
   input  wire logic                         csr_write_enable,
   input  wire logic [gaq_pkg::COUNT_W-1:0]  csr_write_data
);
   import gaq_pkg::*;

   localparam int NV = MAX_VERTICES;
   localparam int AW = $clog2(MAX_VERTICES);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_ROWA = 6'b000010,
      S_ROWB = 6'b000100,
      S_SCAN = 6'b001000,
      S_EMIT = 6'b010000,
      S_RESP = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]  vcount_ff, vcount_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [VIDX_W-1:0]   a_ff, a_in, b_ff, b_in;
   logic                ep_ff, ep_in;
   logic [AW-1:0]       k_ff, k_in;
   logic [DEG_W-1:0]    deg_ff, deg_in, cnt_ff, cnt_in;
   logic                nb_found_ff, nb_found_in;
   logic [VIDX_W-1:0]   nb_idx_ff, nb_idx_in;
   logic                ok_ff, ok_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [NV-1:0]       row_a_ff, row_a_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [VIDX_W-1:0]   rsp_vout_ff, rsp_vout_in;
   logic [DEG_W-1:0]    rsp_deg_ff, rsp_deg_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [COUNT_W-1:0]  n_act;
   logic [NV-1:0]       mask_vec, abit_vec, bbit_vec, kbit_vec, members, row_k_cmp;
   logic [NV-1:0]       rd_row;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [NV-1:0]       mem_wdata;
   logic [COUNT_W-1:0]  k_ext;
   logic                k_last, rowa_bit, is_member, scan_fail, out_free, accept;
   logic                a_oor, b_oor;

   gaq_row_store #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_row  (rd_row)
   );

   assign n_act = (vcount_ff > COUNT_W'(NV)) ? COUNT_W'(NV) : vcount_ff;

   always_comb begin
      for (int i = 0; i < NV; i++) begin
         mask_vec[i] = (COUNT_W'(i) < n_act);
         abit_vec[i] = (a_ff == VIDX_W'(i));
         bbit_vec[i] = (b_ff == VIDX_W'(i));
         kbit_vec[i] = (k_ff == AW'(i));
      end
   end

   assign members   = row_a_ff | abit_vec;
   assign k_ext     = COUNT_W'(k_ff);
   assign k_last    = ((k_ext + COUNT_W'(1)) == n_act);
   assign rowa_bit  = row_a_ff[k_ff];
   assign is_member = members[k_ff];
   // a member's closed neighborhood must equal the start vertex's closed neighborhood
   assign row_k_cmp = (rd_row & mask_vec & ~kbit_vec) | kbit_vec;
   assign scan_fail = is_member && (row_k_cmp != members);

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && req_chan.ready;

   assign a_oor = ({1'b0, req_chan.vertex_a} >= n_act);
   assign b_oor = ({1'b0, req_chan.vertex_b} >= n_act);

   always_comb begin
      state_in      = state_ff;
      vcount_in     = csr_write_enable ? csr_write_data : vcount_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      ep_in         = ep_ff;
      k_in          = k_ff;
      deg_in        = deg_ff;
      cnt_in        = cnt_ff;
      nb_found_in   = nb_found_ff;
      nb_idx_in     = nb_idx_ff;
      ok_in         = ok_ff;
      status_in     = status_ff;
      row_a_in      = row_a_ff;
      mem_we        = 1'b0;
      mem_waddr     = a_ff[AW-1:0];
      mem_wdata     = rd_row;
      mem_raddr     = a_ff[AW-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_vout_in   = rsp_vout_ff;
      rsp_deg_in    = rsp_deg_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_chan.opcode;
               a_in        = req_chan.vertex_a;
               b_in        = req_chan.vertex_b;
               ep_in       = req_chan.edge_present;
               k_in        = '0;
               deg_in      = '0;
               cnt_in      = '0;
               nb_found_in = 1'b0;
               nb_idx_in   = '0;
               ok_in       = 1'b1;
               status_in   = ST_OK;
               if (a_oor || (req_chan.opcode == OP_WRITE && b_oor)) begin
                  status_in = ST_RANGE;
                  state_in  = S_RESP;
               end else if (req_chan.opcode == OP_WRITE &&
                            req_chan.vertex_a == req_chan.vertex_b) begin
                  status_in = ST_SELF;
                  state_in  = S_RESP;
               end else begin
                  mem_raddr = req_chan.vertex_a[AW-1:0];
                  state_in  = S_ROWA;
               end
            end
         end
         S_ROWA: begin
            if (op_ff == OP_WRITE) begin
               mem_we    = 1'b1;
               mem_waddr = a_ff[AW-1:0];
               mem_wdata = ep_ff ? (rd_row | bbit_vec) : (rd_row & ~bbit_vec);
               mem_raddr = b_ff[AW-1:0];
               state_in  = S_ROWB;
            end else begin
               row_a_in  = rd_row & mask_vec & ~abit_vec;
               mem_raddr = '0;
               k_in      = '0;
               state_in  = S_SCAN;
            end
         end
         S_ROWB: begin
            mem_we    = 1'b1;
            mem_waddr = b_ff[AW-1:0];
            mem_wdata = ep_ff ? (rd_row | abit_vec) : (rd_row & ~abit_vec);
            state_in  = S_RESP;
         end
         S_SCAN: begin
            deg_in = deg_ff + {{(DEG_W-1){1'b0}}, rowa_bit};
            if (op_ff == OP_NEXT && !nb_found_ff && rowa_bit &&
                (k_ext >= {1'b0, b_ff})) begin
               nb_found_in = 1'b1;
               nb_idx_in   = VIDX_W'(k_ff);
            end
            if (scan_fail) begin
               ok_in = 1'b0;
            end
            if (k_last) begin
               k_in = '0;
               if (op_ff == OP_CLIQUE && ok_ff && !scan_fail) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               k_in      = k_ff + AW'(1);
               mem_raddr = k_ff + AW'(1);
            end
         end
         S_EMIT: begin
            if (is_member) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_found_in  = 1'b1;
                  rsp_vout_in   = VIDX_W'(k_ff);
                  rsp_deg_in    = deg_ff;
                  rsp_last_in   = (cnt_ff == deg_ff);
                  if (cnt_ff == deg_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     cnt_in = cnt_ff + DEG_W'(1);
                     k_in   = k_ff + AW'(1);
                  end
               end
            end else begin
               k_in = k_ff + AW'(1);
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = nb_found_ff;
               rsp_vout_in   = nb_idx_ff;
               rsp_deg_in    = deg_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vcount_ff    <= VCOUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      ep_ff         <= ep_in;
      k_ff          <= k_in;
      deg_ff        <= deg_in;
      cnt_ff        <= cnt_in;
      nb_found_ff   <= nb_found_in;
      nb_idx_ff     <= nb_idx_in;
      ok_ff         <= ok_in;
      status_ff     <= status_in;
      row_a_ff      <= row_a_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_vout_ff   <= rsp_vout_in;
      rsp_deg_ff    <= rsp_deg_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.vertex_out = rsp_vout_ff;
   assign rsp_chan.degree     = rsp_deg_ff;
   assign rsp_chan.last       = rsp_last_ff;

endmodule
`default_nettype wire

>>> hdl/gaq_checker.sv
// Port-level assertions for the query engine, bound to the top level.
`default_nettype none
module gaq_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [gaq_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic                          rsp_found,
   input wire logic [gaq_pkg::VIDX_W-1:0]    rsp_vertex_out,
   input wire logic [gaq_pkg::DEG_W-1:0]     rsp_degree,
   input wire logic                          rsp_last
);
   import gaq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_status) && $stable(rsp_found) && $stable(rsp_vertex_out) &&
         $stable(rsp_degree) && $stable(rsp_last))
      else $error("response payload changed while stalled");

   // error answers carry nothing but the status and close the request
   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_last && !rsp_found && rsp_vertex_out == '0 && rsp_degree == '0)
      else $error("error response with nonzero fields");

   // only clique member streams produce more than one response
   a_multi_is_clique: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_found && rsp_status == ST_OK)
      else $error("non-final response outside a clique member stream");

endmodule

bind graph_adjacency_query_engine_top gaq_checker u_gaq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_found      (rsp_chan.found),
   .rsp_vertex_out (rsp_chan.vertex_out),
   .rsp_degree     (rsp_chan.degree),
   .rsp_last       (rsp_chan.last)
);
`default_nettype wire
